// ===== rtl/lpbp_pkg.sv =====
// Shared constants, configuration register indexes and status types
// for the LED pulse bit packer. No dependencies.
package lpbp_pkg;

    localparam int COLOR_W        = 24;   // width of the colour port
    localparam int COLOR_BITS_DEF = 24;   // colour bits sent per LED
    localparam int PAT_W          = 3;    // slots per colour bit
    localparam int WORD_W         = 32;   // slots per output word
    localparam int FILL_W         = 5;    // slot count within a word
    localparam int LED_W          = 11;
    localparam int MAX_LEDS       = 1024;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 11;
    localparam int QDEPTH         = 2;
    localparam int QPTR_W         = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W         = $clog2(QDEPTH + 1);

    // frame length clamp, kept within the counter range
    localparam int LIMIT_CAP_I    = (MAX_LEDS > (1 << LED_W) - 1) ? (1 << LED_W) - 1 : MAX_LEDS;
    localparam logic [LED_W-1:0] LIMIT_CAP = LED_W'(LIMIT_CAP_I);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_PATTERN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PATTERN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT    = 2'd2;

    localparam logic [PAT_W-1:0] ONE_PATTERN_RST  = 3'd6;
    localparam logic [PAT_W-1:0] ZERO_PATTERN_RST = 3'd4;
    localparam logic [LED_W-1:0] LED_COUNT_RST    = 11'd1;

    typedef struct packed {
        logic              full;
        logic [QCNT_W-1:0] count;
    } t_q_status;

endpackage

// ===== rtl/lpbp_front.sv =====
// Front end: configuration registers, frame counting and expansion of a
// colour word into its pulse slots. Uses lpbp_pkg.
module lpbp_front #(
    parameter int COLOR_BITS = lpbp_pkg::COLOR_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lpbp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lpbp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [lpbp_pkg::COLOR_W-1:0]     i_color,
    output logic                             o_push_valid,
    input  logic                             i_push_ready,
    output logic [COLOR_BITS*lpbp_pkg::PAT_W:0] o_push_data
);

    localparam int SLOTS = COLOR_BITS * lpbp_pkg::PAT_W;
    localparam int LW    = lpbp_pkg::LED_W;
    localparam int PW    = lpbp_pkg::PAT_W;

    logic [PW-1:0]    r_one;
    logic [PW-1:0]    r_zero;
    logic [LW-1:0]    r_led_count;
    logic [LW-1:0]    r_led_index;
    logic [LW-1:0]    w_limit;
    logic [LW:0]      w_index_inc;
    logic             w_frame_end;
    logic             w_accept;
    logic [SLOTS-1:0] w_slots;

    assign o_cfg_ready  = 1'b1;
    assign o_in_ready   = i_push_ready;
    assign o_push_valid = i_in_valid;
    assign w_accept     = i_in_valid && i_push_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one       <= lpbp_pkg::ONE_PATTERN_RST;
            r_zero      <= lpbp_pkg::ZERO_PATTERN_RST;
            r_led_count <= lpbp_pkg::LED_COUNT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == lpbp_pkg::CFG_ONE_PATTERN) begin
                r_one <= i_cfg_data[PW-1:0];
            end else if (i_cfg_index == lpbp_pkg::CFG_ZERO_PATTERN) begin
                r_zero <= i_cfg_data[PW-1:0];
            end else if (i_cfg_index == lpbp_pkg::CFG_LED_COUNT) begin
                r_led_count <= i_cfg_data[LW-1:0];
            end
        end
    end

    // zero counts as one LED, large counts clamp to the frame maximum
    always_comb begin
        w_limit = r_led_count;
        if (r_led_count == '0) begin
            w_limit = LW'(1);
        end else if (r_led_count > lpbp_pkg::LIMIT_CAP) begin
            w_limit = lpbp_pkg::LIMIT_CAP;
        end
    end

    assign w_index_inc = {1'b0, r_led_index} + (LW+1)'(1);
    assign w_frame_end = w_index_inc >= {1'b0, w_limit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_index <= '0;
        end else if (w_accept) begin
            r_led_index <= w_frame_end ? '0 : w_index_inc[LW-1:0];
        end
    end

    // colour MSB lands in the top slot group; bits above the port send zero
    for (genvar b = 0; b < COLOR_BITS; b++) begin : g_bit
        if (b < lpbp_pkg::COLOR_W) begin : g_in
            assign w_slots[PW*b +: PW] = i_color[b] ? r_one : r_zero;
        end else begin : g_pad
            assign w_slots[PW*b +: PW] = r_zero;
        end
    end

    assign o_push_data = {w_frame_end, w_slots};

endmodule

// ===== rtl/lpbp_queue.sv =====
// Short register queue between the front and back ends.
// Uses lpbp_pkg for depth and status type.
module lpbp_queue #(
    parameter int WIDTH = lpbp_pkg::COLOR_BITS_DEF * lpbp_pkg::PAT_W + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push_valid,
    output logic                  o_push_ready,
    input  logic [WIDTH-1:0]      i_push_data,
    output logic                  o_pop_valid,
    input  logic                  i_pop_ready,
    output logic [WIDTH-1:0]      o_pop_data,
    output lpbp_pkg::t_q_status   o_status
);

    localparam int PW = lpbp_pkg::QPTR_W;
    localparam int CW = lpbp_pkg::QCNT_W;
    localparam logic [PW-1:0] LAST = PW'(lpbp_pkg::QDEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(lpbp_pkg::QDEPTH);

    logic [WIDTH-1:0] r_mem [lpbp_pkg::QDEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = r_count != FULL;
    assign o_pop_valid  = r_count != '0;
    assign o_pop_data   = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    assign o_status.full  = r_count == FULL;
    assign o_status.count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

// ===== rtl/lpbp_back.sv =====
// Back end: packs the slots of one queued LED into 32-slot words, one
// word a cycle into the output register unless it stalls. Uses lpbp_pkg.
module lpbp_back #(
    parameter int COLOR_BITS = lpbp_pkg::COLOR_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_entry_valid,
    output logic                                o_entry_ready,
    input  logic [COLOR_BITS*lpbp_pkg::PAT_W:0] i_entry,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [lpbp_pkg::WORD_W-1:0]         o_pulse_word,
    output logic                                o_run_end,
    output logic                                o_frame_end
);

    localparam int SLOTS = COLOR_BITS * lpbp_pkg::PAT_W;
    localparam int WW    = lpbp_pkg::WORD_W;
    localparam int FW    = lpbp_pkg::FILL_W;
    localparam int BUF_W = SLOTS + WW;
    localparam int REM_W = $clog2(SLOTS + 1);
    localparam int TW    = FW + 1;
    localparam int SUM_W = ((REM_W > TW) ? REM_W : TW) + 1;

    logic             r_busy;
    logic [BUF_W-1:0] r_buf;
    logic [REM_W-1:0] r_rem;
    logic             r_fe;
    logic [WW-1:0]    r_acc;
    logic [FW-1:0]    r_fill;
    logic             r_out_valid;
    logic [WW-1:0]    r_word;
    logic             r_run_end;
    logic             r_frame_end;

    logic [BUF_W-1:0] n_buf;
    logic [REM_W-1:0] n_rem;
    logic [WW-1:0]    n_acc;
    logic [FW-1:0]    n_fill;

    logic [TW-1:0]    w_take;
    logic [WW-1:0]    w_win;
    logic [WW-1:0]    w_word;
    logic [SUM_W-1:0] w_sum;
    logic             w_full;
    logic [REM_W-1:0] w_rem_new;
    logic [BUF_W-1:0] w_buf_sh;
    logic             w_more;
    logic             w_emit;
    logic             w_emit_run;
    logic             w_emit_fe;
    logic             w_done;
    logic             w_go;
    logic             w_load;

    assign w_take    = TW'(WW) - {1'b0, r_fill};
    assign w_win     = r_buf[BUF_W-1 -: WW];
    assign w_word    = r_acc | (w_win >> r_fill);
    assign w_sum     = SUM_W'(r_fill) + SUM_W'(r_rem);
    assign w_full    = w_sum >= SUM_W'(WW);
    assign w_rem_new = r_rem - REM_W'(w_take);
    assign w_buf_sh  = r_buf << w_take;
    // another word follows if a full word remains or a frame flush is due
    assign w_more    = (SUM_W'(w_rem_new) >= SUM_W'(WW)) || (r_fe && w_rem_new != '0);

    always_comb begin
        n_buf      = r_buf;
        n_rem      = r_rem;
        n_acc      = r_acc;
        n_fill     = r_fill;
        w_emit     = 1'b0;
        w_emit_run = 1'b0;
        w_emit_fe  = 1'b0;
        w_done     = 1'b0;
        if (w_full) begin
            w_emit     = 1'b1;
            w_emit_run = !w_more;
            w_emit_fe  = r_fe && (w_rem_new == '0);
            if (w_more) begin
                n_acc  = '0;
                n_fill = '0;
                n_buf  = w_buf_sh;
                n_rem  = w_rem_new;
            end else begin
                // leftover slots start the next partial word
                n_acc  = w_buf_sh[BUF_W-1 -: WW];
                n_fill = FW'(w_rem_new);
                w_done = 1'b1;
            end
        end else if (r_fe) begin
            // frame flush of the partial word, zero padded
            w_emit     = 1'b1;
            w_emit_run = 1'b1;
            w_emit_fe  = 1'b1;
            n_acc      = '0;
            n_fill     = '0;
            w_done     = 1'b1;
        end else begin
            n_acc  = w_word;
            n_fill = FW'(w_sum);
            w_done = 1'b1;
        end
    end

    assign w_go          = r_busy && (!w_emit || !r_out_valid || i_out_ready);
    assign o_entry_ready = !r_busy || (w_go && w_done);
    assign w_load        = i_entry_valid && o_entry_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_acc       <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
            end else if (w_go && w_done) begin
                r_busy <= 1'b0;
            end
            if (w_go) begin
                r_acc  <= n_acc;
                r_fill <= n_fill;
            end
            if (w_go && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_buf <= {i_entry[SLOTS-1:0], {WW{1'b0}}};
            r_rem <= REM_W'(SLOTS);
            r_fe  <= i_entry[SLOTS];
        end else if (w_go) begin
            r_buf <= n_buf;
            r_rem <= n_rem;
        end
        if (w_go && w_emit) begin
            r_word      <= w_word;
            r_run_end   <= w_emit_run;
            r_frame_end <= w_emit_fe;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pulse_word = r_word;
    assign o_run_end    = r_run_end;
    assign o_frame_end  = r_frame_end;

endmodule

// ===== rtl/led_pulse_bit_packer_core.sv =====
// Channel   Handshake                   Word carried
// cfg       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
// in        i_in_valid  / o_in_ready    i_color
// out       o_out_valid / i_out_ready   o_pulse_word, o_run_end, o_frame_end
//
// One output word per cycle from the back-end packer unless the output stalls;
// an LED of 24 colour bits gives 72 slots, so 2 or 3 words (one more word on
// a frame flush). Intake takes one colour word per cycle until the two-entry
// queue fills. Reset is synchronous, active low, and needs no clearing pass.
// A stalled output holds the back end; the front keeps accepting into the queue.
// Top level; uses lpbp_pkg, lpbp_front, lpbp_queue and lpbp_back.
module led_pulse_bit_packer_core #(
    parameter int COLOR_BITS = lpbp_pkg::COLOR_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lpbp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lpbp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [lpbp_pkg::COLOR_W-1:0]     i_color,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [lpbp_pkg::WORD_W-1:0]      o_pulse_word,
    output logic                             o_run_end,
    output logic                             o_frame_end
);

    localparam int ENTRY_W = COLOR_BITS * lpbp_pkg::PAT_W + 1;

    logic                 w_push_valid;
    logic [ENTRY_W-1:0]   w_push_data;
    logic                 w_push_ready;
    logic                 w_pop_valid;
    logic                 w_pop_ready;
    logic [ENTRY_W-1:0]   w_pop_data;
    lpbp_pkg::t_q_status  w_q_status;

    lpbp_front #(.COLOR_BITS(COLOR_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_color      (i_color),
        .o_push_valid (w_push_valid),
        .i_push_ready (!w_q_status.full),
        .o_push_data  (w_push_data)
    );

    lpbp_queue #(.WIDTH(ENTRY_W)) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data),
        .o_status     (w_q_status)
    );

    lpbp_back #(.COLOR_BITS(COLOR_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_valid (w_pop_valid),
        .o_entry_ready (w_pop_ready),
        .i_entry       (w_pop_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pulse_word  (o_pulse_word),
        .o_run_end     (o_run_end),
        .o_frame_end   (o_frame_end)
    );

`ifndef NO_ASSERTIONS
    // the last word of a frame is always the last word of its LED
    a_frame_is_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_end |-> o_run_end)
        else $error("frame end word without run end");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_status.count <= lpbp_pkg::QCNT_W'(lpbp_pkg::QDEPTH))
        && (w_push_ready == !w_q_status.full))
        else $error("queue occupancy out of range");

    a_out_clear_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output word valid straight after reset");
`endif

endmodule

// ===== tb/led_pulse_bit_packer_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for led_pulse_bit_packer_core: colour words in, packed pulse
// words out, checked against an in-bench packer model. Depends on lpbp_pkg and the core.
module led_pulse_bit_packer_core_test;

    // spare register index, writes to it must leave the block unchanged
    localparam logic [lpbp_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [lpbp_pkg::WORD_W-1:0] pulse_word;
        logic                        run_end;
        logic                        frame_end;
    } t_pulse_word;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [lpbp_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [lpbp_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic [lpbp_pkg::COLOR_W-1:0]    i_color;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic [lpbp_pkg::WORD_W-1:0]     o_pulse_word;
    logic                            o_run_end;
    logic                            o_frame_end;

    // packer model state and its copy of the registers
    logic [lpbp_pkg::PAT_W-1:0]  one_pat;
    logic [lpbp_pkg::PAT_W-1:0]  zero_pat;
    logic [lpbp_pkg::LED_W-1:0]  frame_leds;
    logic [lpbp_pkg::WORD_W-1:0] slot_acc;
    int                          slot_fill;
    int                          led_pos;

    t_pulse_word words_due[$];
    int          err_count = 0;
    int          cycle_count = 0;
    bit          idle_on = 1'b1;

    led_pulse_bit_packer_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_color      (i_color),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pulse_word (o_pulse_word),
        .o_run_end    (o_run_end),
        .o_frame_end  (o_frame_end)
    );

    always #6 i_clk = ~i_clk;

    // Expands one LED into slots, queues every word it completes, flushes at frame end.
    function automatic void pack_led(input logic [lpbp_pkg::COLOR_W-1:0] color);
        t_pulse_word                made[$];
        t_pulse_word                w;
        logic [lpbp_pkg::PAT_W-1:0] pat;
        int                         limit;
        for (int b = lpbp_pkg::COLOR_BITS_DEF - 1; b >= 0; b--) begin
            pat = (b < lpbp_pkg::COLOR_W && color[b]) ? one_pat : zero_pat;
            for (int s = lpbp_pkg::PAT_W - 1; s >= 0; s--) begin
                slot_acc[lpbp_pkg::WORD_W - 1 - slot_fill] = pat[s];
                slot_fill++;
                if (slot_fill == lpbp_pkg::WORD_W) begin
                    w.pulse_word = slot_acc;
                    w.run_end = 1'b0;
                    w.frame_end = 1'b0;
                    made.push_back(w);
                    slot_acc = '0;
                    slot_fill = 0;
                end
            end
        end
        limit = (frame_leds == 0) ? 1 :
                ((frame_leds > lpbp_pkg::MAX_LEDS) ? lpbp_pkg::MAX_LEDS : frame_leds);
        led_pos++;
        if (led_pos >= limit) begin
            if (slot_fill != 0) begin
                w.pulse_word = slot_acc;
                w.run_end = 1'b0;
                w.frame_end = 1'b0;
                made.push_back(w);
                slot_acc = '0;
                slot_fill = 0;
            end
            if (made.size() != 0) begin
                w = made.pop_back();
                w.frame_end = 1'b1;
                made.push_back(w);
            end
            led_pos = 0;
        end
        if (made.size() != 0) begin
            w = made.pop_back();
            w.run_end = 1'b1;
            made.push_back(w);
        end
        foreach (made[k]) words_due.push_back(made[k]);
    endfunction

    task automatic flag_mismatch(input string what, input logic [lpbp_pkg::WORD_W-1:0] got,
                                 input logic [lpbp_pkg::WORD_W-1:0] want);
        $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
        err_count++;
    endtask

    task automatic send_color(input logic [lpbp_pkg::COLOR_W-1:0] color);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_color = color;
        do @(posedge i_clk); while (!o_in_ready);
        pack_led(color);
    endtask

    task automatic write_reg(input logic [lpbp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lpbp_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            lpbp_pkg::CFG_ONE_PATTERN:  one_pat = data[lpbp_pkg::PAT_W-1:0];
            lpbp_pkg::CFG_ZERO_PATTERN: zero_pat = data[lpbp_pkg::PAT_W-1:0];
            lpbp_pkg::CFG_LED_COUNT:    frame_leds = data[lpbp_pkg::LED_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // stop sending and wait for every due word, then idle for the given quiet count
    task automatic drain(input int quiet);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (words_due.size() != 0) @(negedge i_clk);
        repeat (quiet) @(negedge i_clk);
    endtask

    function automatic logic [lpbp_pkg::COLOR_W-1:0] pick_color();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            default: return lpbp_pkg::COLOR_W'($urandom);
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_color(24'h000000);
        send_color(24'hFFFFFF);
        send_color(24'hA5A5A5);
        drain(8);
    endtask

    task automatic test_pattern_extremes();
        write_reg(lpbp_pkg::CFG_ONE_PATTERN, 11'h7FF);
        write_reg(lpbp_pkg::CFG_ZERO_PATTERN, 11'h7F8);
        write_reg(CFG_SPARE, 11'h7FF);
        send_color(24'hFFFFFF);
        send_color(24'h000000);
        send_color(24'h800001);
        drain(8);
        write_reg(lpbp_pkg::CFG_ONE_PATTERN, 11'h000);
        write_reg(lpbp_pkg::CFG_ZERO_PATTERN, 11'h007);
        send_color(24'h7FFFFE);
        send_color(24'hFFFFFF);
        drain(8);
    endtask

    // four LEDs make 288 slots, so each frame closes exactly on a word edge
    task automatic test_word_boundary();
        write_reg(lpbp_pkg::CFG_ONE_PATTERN, lpbp_pkg::CFG_DATA_W'(lpbp_pkg::ONE_PATTERN_RST));
        write_reg(lpbp_pkg::CFG_ZERO_PATTERN, lpbp_pkg::CFG_DATA_W'(lpbp_pkg::ZERO_PATTERN_RST));
        write_reg(lpbp_pkg::CFG_LED_COUNT, 11'd4);
        repeat (8) send_color(pick_color());
        drain(8);
    endtask

    task automatic test_count_limits();
        write_reg(lpbp_pkg::CFG_LED_COUNT, 11'd0);
        send_color(24'h123456);
        send_color(24'hFEDCBA);
        drain(8);
        write_reg(lpbp_pkg::CFG_LED_COUNT, 11'h7FF);
        repeat (3) send_color(pick_color());
        drain(8);
        // frame already three LEDs long, so the next LED closes it
        write_reg(lpbp_pkg::CFG_LED_COUNT, 11'd2);
        send_color(24'h0F0F0F);
        drain(8);
        write_reg(lpbp_pkg::CFG_LED_COUNT, lpbp_pkg::CFG_DATA_W'(lpbp_pkg::MAX_LEDS));
        repeat (2) send_color(pick_color());
        drain(8);
        write_reg(lpbp_pkg::CFG_LED_COUNT, 11'd1);
        send_color(24'hC3C3C3);
        drain(8);
    endtask

    task automatic test_random_frames();
        int                              sent;
        int                              phase;
        int                              burst;
        logic [lpbp_pkg::CFG_DATA_W-1:0] cnt;
        sent = 0;
        phase = 0;
        while (sent < 90) begin
            write_reg(lpbp_pkg::CFG_ONE_PATTERN,
                      lpbp_pkg::CFG_DATA_W'($urandom_range(0, 2047)));
            write_reg(lpbp_pkg::CFG_ZERO_PATTERN,
                      lpbp_pkg::CFG_DATA_W'($urandom_range(0, 2047)));
            case ($urandom_range(0, 7))
                0:       cnt = '0;
                1:       cnt = lpbp_pkg::CFG_DATA_W'($urandom_range(9, 40));
                2:       cnt = lpbp_pkg::CFG_DATA_W'($urandom_range(1025, 2047));
                default: cnt = lpbp_pkg::CFG_DATA_W'($urandom_range(1, 8));
            endcase
            write_reg(lpbp_pkg::CFG_LED_COUNT, cnt);
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_SPARE, lpbp_pkg::CFG_DATA_W'($urandom));
            idle_on = ($urandom_range(0, 4) != 0);
            burst = $urandom_range(4, 16);
            for (int i = 0; i < burst; i++) begin
                send_color(pick_color());
                sent++;
                // hold off mid-run until the output side has caught up
                if (phase == 1 && i == burst / 2)
                    drain(1);
            end
            drain(8);
            phase++;
        end
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        write_reg(lpbp_pkg::CFG_ONE_PATTERN, lpbp_pkg::CFG_DATA_W'($urandom_range(0, 2047)));
        write_reg(lpbp_pkg::CFG_ZERO_PATTERN, lpbp_pkg::CFG_DATA_W'($urandom_range(0, 2047)));
        write_reg(lpbp_pkg::CFG_LED_COUNT, lpbp_pkg::CFG_DATA_W'($urandom_range(1, 6)));
        repeat (30) send_color(pick_color());
    endtask

    // receiver: stalls in bursts while idling is enabled
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_words
        t_pulse_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (words_due.size() == 0) begin
                flag_mismatch("word with none due", o_pulse_word, '0);
            end else begin
                want = words_due.pop_front();
                if (o_pulse_word !== want.pulse_word)
                    flag_mismatch("pulse_word", o_pulse_word, want.pulse_word);
                if (o_run_end !== want.run_end)
                    flag_mismatch("run_end", lpbp_pkg::WORD_W'(o_run_end),
                                  lpbp_pkg::WORD_W'(want.run_end));
                if (o_frame_end !== want.frame_end)
                    flag_mismatch("frame_end", lpbp_pkg::WORD_W'(o_frame_end),
                                  lpbp_pkg::WORD_W'(want.frame_end));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[led_pulse_bit_packer_core] ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_color = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        one_pat = lpbp_pkg::ONE_PATTERN_RST;
        zero_pat = lpbp_pkg::ZERO_PATTERN_RST;
        frame_leds = lpbp_pkg::LED_COUNT_RST;
        slot_acc = '0;
        slot_fill = 0;
        led_pos = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_pattern_extremes();
        test_word_boundary();
        test_count_limits();
        test_random_frames();
        test_steady_stream();
        drain(20);

        if (err_count == 0)
            $display("[led_pulse_bit_packer_core] OK");
        else
            $display("[led_pulse_bit_packer_core] ERROR");
        $finish;
    end

endmodule
